[hdl/nwt_pkg.sv]
// Shared constants, types and a lookup function for the number-to-word token block.
`default_nettype none
package nwt_pkg;

    localparam int VALUE_W       = 40;
    localparam int NUMBER_GROUPS = 5;
    localparam int NUM_DIGITS    = 3 * NUMBER_GROUPS;
    localparam int BCD_W         = 4 * NUM_DIGITS;
    localparam int GRP_W         = (NUMBER_GROUPS > 1) ? $clog2(NUMBER_GROUPS) : 1;
    localparam int BITS_PER_STEP = 2;
    localparam int CONV_STEPS    = (VALUE_W + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int CNT_W         = (CONV_STEPS > 1) ? $clog2(CONV_STEPS) : 1;

    localparam int CODE_W    = 6;
    localparam int LETTERS_W = 4;

    localparam logic [CODE_W-1:0] CODE_ZERO       = 6'd0;
    localparam logic [CODE_W-1:0] CODE_TEN        = 6'd10;
    localparam logic [CODE_W-1:0] CODE_TENS_BASE  = 6'd18;
    localparam logic [CODE_W-1:0] CODE_HUNDRED    = 6'd28;
    localparam logic [CODE_W-1:0] CODE_AND        = 6'd29;
    localparam logic [CODE_W-1:0] CODE_SCALE_BASE = 6'd29;
    localparam int                MAX_SCALE       = 4;

    // token slots within one group, emitted lowest first
    localparam int NUM_SLOTS   = 6;
    localparam int SLOT_W      = 3;
    localparam int SLOT_HDIGIT = 0;
    localparam int SLOT_HUND   = 1;
    localparam int SLOT_AND    = 2;
    localparam int SLOT_LOW    = 3;
    localparam int SLOT_UNITS  = 4;
    localparam int SLOT_SCALE  = 5;

    typedef struct packed {
        logic load;
        logic shift;
        logic start;
        logic emit;
    } nwt_cmd_t;

    typedef struct packed {
        logic out_free;
        logic token_last;
    } nwt_sts_t;

    function automatic logic [LETTERS_W-1:0] word_letters_of(input logic [CODE_W-1:0] code);
        logic [LETTERS_W-1:0] n;
        case (code)
            6'd0:  n = 4'd4;
            6'd1:  n = 4'd3;
            6'd2:  n = 4'd3;
            6'd3:  n = 4'd5;
            6'd4:  n = 4'd4;
            6'd5:  n = 4'd4;
            6'd6:  n = 4'd3;
            6'd7:  n = 4'd5;
            6'd8:  n = 4'd5;
            6'd9:  n = 4'd4;
            6'd10: n = 4'd3;
            6'd11: n = 4'd6;
            6'd12: n = 4'd6;
            6'd13: n = 4'd8;
            6'd14: n = 4'd8;
            6'd15: n = 4'd7;
            6'd16: n = 4'd7;
            6'd17: n = 4'd9;
            6'd18: n = 4'd8;
            6'd19: n = 4'd8;
            6'd20: n = 4'd6;
            6'd21: n = 4'd6;
            6'd22: n = 4'd5;
            6'd23: n = 4'd5;
            6'd24: n = 4'd5;
            6'd25: n = 4'd7;
            6'd26: n = 4'd6;
            6'd27: n = 4'd6;
            6'd28: n = 4'd7;
            6'd29: n = 4'd3;
            6'd30: n = 4'd8;
            6'd31: n = 4'd7;
            6'd32: n = 4'd7;
            6'd33: n = 4'd8;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

[hdl/nwt_if.sv]
// Valid/ready channel interfaces for the number input and the token output.
`default_nettype none
interface nwt_num_if;
    import nwt_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface nwt_tok_if;
    import nwt_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CODE_W-1:0]    word_code;
    logic [LETTERS_W-1:0] word_letters;
    logic                 last_word;
    modport source (output valid, output word_code, output word_letters, output last_word,
                    input ready);
    modport sink   (input valid, input word_code, input word_letters, input last_word,
                    output ready);
endinterface
`default_nettype wire

[hdl/nwt_ctrl.sv]
// Controller: sequences load, binary-to-BCD conversion, group setup and token emission.
`default_nettype none
module nwt_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire nwt_pkg::nwt_sts_t sts,
    output nwt_pkg::nwt_cmd_t      cmd
);
    import nwt_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CONV  = 2'd1;
    localparam logic [1:0] ST_START = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.shift = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CONV_STEPS - 1))
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.start  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.token_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

[hdl/nwt_dp.sv]
// Datapath: double-dabble converter, group/slot token selection and output register.
`default_nettype none
module nwt_dp
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_wdata,
    input  wire logic [nwt_pkg::VALUE_W-1:0]   value,
    input  wire nwt_pkg::nwt_cmd_t             cmd,
    output nwt_pkg::nwt_sts_t                  sts,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [nwt_pkg::CODE_W-1:0]         word_code,
    output logic [nwt_pkg::LETTERS_W-1:0]      word_letters,
    output logic                               last_word
);
    import nwt_pkg::*;

    typedef logic [NUMBER_GROUPS-1:0][2:0][3:0] bcd_t;

    logic                 and_mode_reg;
    logic [VALUE_W-1:0]   bin_reg;
    bcd_t                 bcd_reg;
    logic [GRP_W-1:0]     grp_reg;
    logic [NUM_SLOTS-1:0] mask_reg;
    logic                 zero_reg;
    logic                 out_valid_reg;
    logic [CODE_W-1:0]    code_reg;
    logic [LETTERS_W-1:0] letters_reg;
    logic                 last_reg;

    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b, input logic bit_in);
        logic [BCD_W-1:0] a;
        a = b;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (a[4*i +: 4] >= 4'd5)
            begin
                a[4*i +: 4] = a[4*i +: 4] + 4'd3;
            end
        end
        return {a[BCD_W-2:0], bit_in};
    endfunction

    function automatic logic [NUM_SLOTS-1:0] slot_mask(input logic [2:0][3:0] d,
                                                       input logic [GRP_W-1:0] g,
                                                       input logic and_on);
        logic [NUM_SLOTS-1:0] m;
        logic                 h_nz;
        logic                 low_nz;
        h_nz   = (d[2] != 4'd0);
        low_nz = (d[1] != 4'd0) || (d[0] != 4'd0);
        m = '0;
        m[SLOT_HDIGIT] = h_nz;
        m[SLOT_HUND]   = h_nz;
        m[SLOT_AND]    = h_nz && low_nz && and_on;
        m[SLOT_LOW]    = low_nz;
        m[SLOT_UNITS]  = (d[1] >= 4'd2) && (d[0] != 4'd0);
        m[SLOT_SCALE]  = (g != '0) && (h_nz || low_nz);
        return m;
    endfunction

    // highest nonzero group strictly below lim; msb flags a find
    function automatic logic [GRP_W:0] pick_below(input logic [NUMBER_GROUPS-1:0] nz,
                                                 input int lim);
        logic [GRP_W:0] r;
        r = '0;
        for (int i = 0; i < NUMBER_GROUPS; i++)
        begin
            if (nz[i] && (i < lim))
            begin
                r = {1'b1, GRP_W'(i)};
            end
        end
        return r;
    endfunction

    logic [BCD_W-1:0]         bcd_shifted;
    logic [NUMBER_GROUPS-1:0] grp_nz;
    logic [GRP_W:0]           top_pick;
    logic [GRP_W:0]           below_pick;
    logic [2:0][3:0]          cur_d;
    logic [NUM_SLOTS-1:0]     low_bit;
    logic [NUM_SLOTS-1:0]     remaining;
    logic [SLOT_W-1:0]        slot;
    logic [CODE_W-1:0]        tok_code;
    logic                     tok_last;
    logic                     out_free;

    assign bcd_shifted = dabble(dabble(BCD_W'(bcd_reg), bin_reg[VALUE_W-1]),
                                bin_reg[VALUE_W-2]);

    always_comb
    begin
        for (int g = 0; g < NUMBER_GROUPS; g++)
        begin
            grp_nz[g] = |bcd_reg[g];
        end
    end

    assign top_pick   = pick_below(grp_nz, NUMBER_GROUPS);
    assign below_pick = pick_below(grp_nz, int'(grp_reg));
    assign cur_d      = bcd_reg[grp_reg];
    assign low_bit    = mask_reg & (~mask_reg + 1'b1);
    assign remaining  = mask_reg & ~low_bit;

    always_comb
    begin
        slot = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                slot = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        tok_code = CODE_ZERO;
        if (!zero_reg)
        begin
            case (slot)
                SLOT_W'(SLOT_HDIGIT): tok_code = {2'b00, cur_d[2]};
                SLOT_W'(SLOT_HUND):   tok_code = CODE_HUNDRED;
                SLOT_W'(SLOT_AND):    tok_code = CODE_AND;
                SLOT_W'(SLOT_LOW):
                begin
                    if (cur_d[1] >= 4'd2)
                    begin
                        tok_code = CODE_TENS_BASE + {2'b00, cur_d[1]};
                    end
                    else if (cur_d[1] == 4'd1)
                    begin
                        tok_code = CODE_TEN + {2'b00, cur_d[0]};
                    end
                    else
                    begin
                        tok_code = {2'b00, cur_d[0]};
                    end
                end
                SLOT_W'(SLOT_UNITS):  tok_code = {2'b00, cur_d[0]};
                SLOT_W'(SLOT_SCALE):
                begin
                    if (int'(grp_reg) > MAX_SCALE)
                    begin
                        tok_code = CODE_SCALE_BASE + CODE_W'(MAX_SCALE);
                    end
                    else
                    begin
                        tok_code = CODE_SCALE_BASE + CODE_W'(grp_reg);
                    end
                end
                default:              tok_code = CODE_ZERO;
            endcase
        end
    end

    assign tok_last = zero_reg || ((remaining == '0) && !below_pick[GRP_W]);
    assign out_free = !out_valid_reg || out_ready;

    assign sts.out_free   = out_free;
    assign sts.token_last = tok_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            and_mode_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
            zero_reg      <= 1'b0;
            mask_reg      <= '0;
            grp_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                and_mode_reg <= cfg_wdata;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.start)
            begin
                zero_reg <= !top_pick[GRP_W];
                grp_reg  <= top_pick[GRP_W-1:0];
                mask_reg <= slot_mask(bcd_reg[top_pick[GRP_W-1:0]],
                                      top_pick[GRP_W-1:0], and_mode_reg);
            end
            else if (cmd.emit && !zero_reg)
            begin
                if (remaining != '0)
                begin
                    mask_reg <= remaining;
                end
                else
                begin
                    grp_reg  <= below_pick[GRP_W-1:0];
                    mask_reg <= slot_mask(bcd_reg[below_pick[GRP_W-1:0]],
                                          below_pick[GRP_W-1:0], and_mode_reg);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg <= value;
            bcd_reg <= '0;
        end
        else if (cmd.shift)
        begin
            bin_reg <= {bin_reg[VALUE_W-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
            bcd_reg <= bcd_t'(bcd_shifted);
        end

        if (cmd.emit)
        begin
            code_reg    <= tok_code;
            letters_reg <= word_letters_of(tok_code);
            last_reg    <= tok_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign word_code    = code_reg;
    assign word_letters = letters_reg;
    assign last_word    = last_reg;

endmodule
`default_nettype wire

[hdl/number_to_word_tokens_core.sv]
// Per number: accept, then 2-bit double-dabble conversion, then group setup, then one word
// token per cycle (1 to 23 tokens) into the output register while that register is free.
// The next number is accepted once the last token is in the output register.
// rst_n (asynchronous, active low) returns the sequencer to idle, empties the output
// register and sets and_mode to 1.
`default_nettype none
module number_to_word_tokens_core
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata,
    nwt_num_if.sink   num,
    nwt_tok_if.source tok
);
    import nwt_pkg::*;

    nwt_cmd_t cmd;
    nwt_sts_t sts;
    logic     in_ready;

    nwt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (num.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    nwt_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .value        (num.value),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (tok.valid),
        .out_ready    (tok.ready),
        .word_code    (tok.word_code),
        .word_letters (tok.word_letters),
        .last_word    (tok.last_word)
    );

    assign num.ready = in_ready;

endmodule
`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for number_to_word_tokens_core, checked token by token.
`timescale 1ns / 1ps
module testbench;
    import nwt_pkg::*;

    localparam int MAX_WORDS       = 23;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 60;
    // letter counts, one nibble per word code, code 0 in the lowest nibble
    localparam logic [34*4-1:0] WORD_LENGTHS = 136'h8778_3766_7555_6688_9778_8663_4553_4453_34;
    localparam longint unsigned ONE_TRILLION = 64'd1_000_000_000_000;

    typedef struct packed {
        logic [CODE_W-1:0]    code;
        logic [LETTERS_W-1:0] letters;
        logic                 last;
    } word_token_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    nwt_num_if num_ch ();
    nwt_tok_if tok_ch ();

    number_to_word_tokens_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .num       (num_ch),
        .tok       (tok_ch)
    );

    logic [VALUE_W-1:0] pending_numbers[$];
    word_token_t        expected_words[$];
    bit                 and_mode_copy = 1'b1;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int                 hold_offs_asked = 0;
    int                 hold_offs_done = 0;
    int                 hold_off_left = 0;
    int                 mismatches = 0;
    int                 cycle_count = 0;

    always #5 clk = ~clk;

    function automatic word_token_t word_token(input int code);
        word_token_t t;
        t.code    = code[CODE_W-1:0];
        t.letters = WORD_LENGTHS[code*4 +: 4];
        t.last    = 1'b0;
        return t;
    endfunction

    // Expected tokens of one number, appended to expected_words
    function automatic void spell_number(input logic [VALUE_W-1:0] v, input bit use_and);
        longint unsigned rest;
        int              grp[NUMBER_GROUPS];
        int              hund;
        int              low;
        bit              any_nonzero;
        word_token_t     words[$];
        rest = v;
        any_nonzero = 1'b0;
        for (int g = 0; g < NUMBER_GROUPS; g++)
        begin
            grp[g] = int'(rest % 1000);
            rest   = rest / 1000;
            if (grp[g] != 0)
                any_nonzero = 1'b1;
        end
        if (!any_nonzero)
            words.push_back(word_token(CODE_ZERO));
        else
        begin
            for (int g = NUMBER_GROUPS - 1; g >= 0; g--)
            begin
                if (grp[g] != 0)
                begin
                    hund = grp[g] / 100;
                    low  = grp[g] % 100;
                    if (hund != 0)
                    begin
                        words.push_back(word_token(hund));
                        words.push_back(word_token(CODE_HUNDRED));
                        if (low != 0 && use_and)
                            words.push_back(word_token(CODE_AND));
                    end
                    if (low != 0 && low < 20)
                        words.push_back(word_token(low));
                    else if (low != 0)
                    begin
                        words.push_back(word_token(CODE_TENS_BASE + low / 10));
                        if (low % 10 != 0)
                            words.push_back(word_token(low % 10));
                    end
                    // scale words above Trillion fold onto Trillion
                    if (g > 0)
                        words.push_back(word_token(CODE_SCALE_BASE +
                                                   ((g > MAX_SCALE) ? MAX_SCALE : g)));
                end
            end
        end
        while (words.size() > MAX_WORDS)
            void'(words.pop_back());
        words[words.size() - 1].last = 1'b1;
        foreach (words[i])
            expected_words.push_back(words[i]);
    endfunction

    function automatic int random_group();
        case ($urandom_range(7))
            0: return 0;
            1: return $urandom_range(1, 19);
            2: return 10 * $urandom_range(2, 9);
            3: return 100 * $urandom_range(1, 9);
            4: return 100 * $urandom_range(1, 9) + $urandom_range(1, 19);
            5: return $urandom_range(999);
            6: return 777;
            default: return $urandom_range(20, 99);
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] random_number();
        logic [63:0]     raw;
        longint unsigned acc;
        int              grp;
        bit              trillions;
        raw = {$urandom, $urandom};
        acc = 0;
        case ($urandom_range(9))
            0, 1: return raw[VALUE_W-1:0];
            2: return VALUE_W'($urandom_range(999));
            default:
            begin
                trillions = ($urandom_range(3) == 0);
                for (int g = 3; g >= 0; g--)
                begin
                    grp = random_group();
                    // keep one trillion plus the rest inside 40 bits
                    if (g == 3 && trillions && grp > 98)
                        grp = grp % 99;
                    acc = acc * 1000 + grp;
                end
                if (trillions)
                    acc = acc + ONE_TRILLION;
                return acc[VALUE_W-1:0];
            end
        endcase
    endfunction

    function automatic void queue_directed();
        pending_numbers.push_back(40'd0);
        pending_numbers.push_back(40'd1);
        pending_numbers.push_back(40'd7);
        pending_numbers.push_back(40'd13);
        pending_numbers.push_back(40'd19);
        pending_numbers.push_back(40'd20);
        pending_numbers.push_back(40'd45);
        pending_numbers.push_back(40'd99);
        pending_numbers.push_back(40'd100);
        pending_numbers.push_back(40'd101);
        pending_numbers.push_back(40'd115);
        pending_numbers.push_back(40'd120);
        pending_numbers.push_back(40'd999);
        pending_numbers.push_back(40'd1_000);
        pending_numbers.push_back(40'd1_000_001);
        pending_numbers.push_back(40'd2_000_000_000);
        pending_numbers.push_back(40'd500_000_000_010);
        pending_numbers.push_back(40'd1_000_000_000_000);
        pending_numbers.push_back(40'd1_000_100_010_001);
        pending_numbers.push_back(40'd777_777_777_777);
        pending_numbers.push_back({VALUE_W{1'b1}});
    endfunction

    function automatic void queue_random(input int count);
        for (int i = 0; i < count; i++)
            pending_numbers.push_back(random_number());
    endfunction

    task automatic wait_drained(input int settle);
        while (pending_numbers.size() != 0 || num_ch.valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_and_mode(input bit m);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        and_mode_copy = m;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Number driver: prediction is made on the accepting edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (num_ch.valid && num_ch.ready)
                spell_number(num_ch.value, and_mode_copy);
            if (!num_ch.valid || num_ch.ready)
            begin
                if (pending_numbers.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    num_ch.valid <= 1'b1;
                    num_ch.value <= pending_numbers.pop_front();
                end
                else
                    num_ch.valid <= 1'b0;
            end
        end
    end

    // Token monitor and receiver back-pressure
    always @(posedge clk)
    begin : token_monitor
        word_token_t want;
        if (rst_n)
        begin
            if (tok_ch.valid && tok_ch.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected token: word_code %0d", tok_ch.word_code);
                    mismatches++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (tok_ch.word_code !== want.code)
                    begin
                        $error("word_code: expected %0d, got %0d", want.code, tok_ch.word_code);
                        mismatches++;
                    end
                    if (tok_ch.word_letters !== want.letters)
                    begin
                        $error("word_letters: expected %0d, got %0d", want.letters,
                               tok_ch.word_letters);
                        mismatches++;
                    end
                    if (tok_ch.last_word !== want.last)
                    begin
                        $error("last_word: expected %0d, got %0d", want.last, tok_ch.last_word);
                        mismatches++;
                    end
                end
            end
            if (hold_off_left == 0 && hold_offs_done < hold_offs_asked)
            begin
                hold_off_left = HOLD_OFF_CYCLES;
                hold_offs_done++;
            end
            if (hold_off_left != 0)
            begin
                hold_off_left--;
                tok_ch.ready <= 1'b0;
            end
            else
                tok_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        num_ch.valid = 1'b0;
        num_ch.value = '0;
        tok_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // and_mode at its reset value
        set_idling(23, 67);
        queue_directed();
        queue_random(47);
        wait_drained(SETTLE_CYCLES);

        write_and_mode(1'b0);
        set_idling(67, 23);
        queue_directed();
        queue_random(47);
        hold_offs_asked++;
        wait_drained(SETTLE_CYCLES);

        // no idling; long receiver stall backs the block up
        write_and_mode(1'b1);
        set_idling(0, 0);
        queue_random(47);
        hold_offs_asked++;
        wait_drained(SETTLE_CYCLES);

        write_and_mode(1'b0);
        set_idling(23, 67);
        queue_random(47);
        wait_drained(TAIL_CYCLES);

        if (mismatches == 0 && expected_words.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[sim.f]
hdl/nwt_pkg.sv
hdl/nwt_if.sv
hdl/nwt_ctrl.sv
hdl/nwt_dp.sv
hdl/number_to_word_tokens_core.sv
test/testbench.sv
